// ----- rtl/fifo_resource_lock_queues_top_defines.svh -----
// Assertion macros shared by the lock queue checker.
`ifndef FIFO_RESOURCE_LOCK_QUEUES_TOP_DEFINES_SVH
`define FIFO_RESOURCE_LOCK_QUEUES_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FRLQ_AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frlq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FRLQ_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frlq assertion failed");

`endif

// ----- rtl/frlq_pkg.sv -----
// Types and codes shared by the resource lock queue modules.
`timescale 1ns / 1ps
package frlq_pkg;

    localparam int RES_W = 5;
    localparam int TID_W = 16;

    typedef enum logic [1:0] {
        REQ_TAKE   = 2'd0,
        REQ_GIVE   = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_WAITING  = 3'd1,
        ST_REFUSED  = 3'd2,
        ST_RELEASED = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_BYPASS   = 3'd5,
        ST_REMOVE   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_TAKE,
        CELL_GIVE,
        CELL_START,
        CELL_STEP,
        CELL_REPORT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [RES_W-1:0] resource;
        logic [TID_W-1:0] task_id;
        logic             caller_untracked;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [RES_W-1:0] resource_out;
        logic             wake_valid;
        logic [TID_W-1:0] wake_task;
        logic             was_removed;
        logic             last;
    } t_out_item;

endpackage

// ----- rtl/frlq_cell.sv -----
// One resource queue cell: holds a FIFO of task ids with the head at slot 0.
`timescale 1ns / 1ps
module frlq_cell #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TASK_ID_BITS  = 16,
    parameter int NUM_RESOURCES = 16,
    parameter int CELL_INDEX    = 0,
    localparam int SW = $clog2(QUEUE_DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  frlq_pkg::t_cell_op       i_op,
    input  logic [TASK_ID_BITS-1:0]  i_tid,
    input  logic [SW-1:0]            i_step,
    input  frlq_pkg::t_out_item      i_chain,
    output frlq_pkg::t_out_item      o_chain,
    output frlq_pkg::t_out_item      o_resp
);
    import frlq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [TASK_ID_BITS-1:0] r_q [QUEUE_DEPTH];
    logic [TASK_ID_BITS-1:0] n_q [QUEUE_DEPTH];
    logic [CW-1:0]           r_cnt, n_cnt, r_cnt0, w_tail;
    logic                    r_removed, n_removed;
    t_out_item               r_rep, w_rep;
    logic                    w_full, w_empty, w_head_hit, w_step_act;

    assign w_full     = (r_cnt == CW'(QUEUE_DEPTH));
    assign w_empty    = (r_cnt == '0);
    assign w_head_hit = (r_q[0] == i_tid);
    assign w_step_act = (CW'(i_step) < r_cnt0);
    assign w_tail     = r_cnt - CW'(1);

    always_comb begin
        o_resp              = '0;
        o_resp.resource_out = RES_W'(CELL_INDEX);
        o_resp.last         = 1'b1;
        o_resp.status       = ST_IGNORED;
        case (i_op)
            CELL_TAKE: begin
                if (w_full) begin
                    o_resp.status = ST_REFUSED;
                end else if (w_empty || w_head_hit) begin
                    o_resp.status = ST_GRANTED;
                end else begin
                    o_resp.status = ST_WAITING;
                end
            end
            CELL_GIVE: begin
                if (!w_empty && w_head_hit) begin
                    o_resp.status     = ST_RELEASED;
                    o_resp.wake_valid = (r_cnt > CW'(1));
                    o_resp.wake_task  = (r_cnt > CW'(1)) ? TID_W'(r_q[1]) : '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_rep              = '0;
        w_rep.status       = ST_REMOVE;
        w_rep.resource_out = RES_W'(CELL_INDEX);
        w_rep.was_removed  = r_removed;
        w_rep.wake_valid   = r_removed && !w_empty;
        w_rep.wake_task    = (r_removed && !w_empty) ? TID_W'(r_q[0]) : '0;
        w_rep.last         = (CELL_INDEX == NUM_RESOURCES - 1);
    end

    always_comb begin
        n_q       = r_q;
        n_cnt     = r_cnt;
        n_removed = r_removed;
        case (i_op)
            CELL_TAKE: begin
                if (!w_full) begin
                    n_q[r_cnt[IW-1:0]] = i_tid;
                    n_cnt              = r_cnt + CW'(1);
                end
            end
            CELL_GIVE: begin
                if (!w_empty && w_head_hit) begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        n_q[i] = r_q[i+1];
                    end
                    n_cnt = w_tail;
                end
            end
            CELL_START: begin
                n_removed = 1'b0;
            end
            CELL_STEP: begin
                // rotate the head to the tail, or drop it when it matches
                if (w_step_act) begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        n_q[i] = r_q[i+1];
                    end
                    if (w_head_hit) begin
                        n_cnt     = w_tail;
                        n_removed = 1'b1;
                    end else begin
                        n_q[w_tail[IW-1:0]] = r_q[0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_removed <= 1'b0;
        end else begin
            r_q       <= n_q;
            r_cnt     <= n_cnt;
            r_removed <= n_removed;
            if (i_op == CELL_START) begin
                r_cnt0 <= r_cnt;
            end
            if (i_op == CELL_REPORT) begin
                r_rep <= w_rep;
            end else if (i_op == CELL_SHIFT) begin
                r_rep <= i_chain;
            end
        end
    end

    assign o_chain = r_rep;

endmodule

// ----- rtl/fifo_resource_lock_queues_top.sv -----
// Top level of the resource lock queues: request sequencer and a row of queue cells.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | i_in  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out (t_out_item)
//
// Take, give and bypass: one transfer in; result registered, then moved to the output register.
// Remove: the cells rotate and compact their queues in parallel (S_RM_PASS), load their reports
// (S_RM_LOAD), then one report per resource, one per cycle while the output is not stalled.
// The input stalls while a request is in progress; the output register holds a result
// under stall while the next request is taken. Synchronous active-low reset empties all queues.
`timescale 1ns / 1ps
module fifo_resource_lock_queues_top #(
    parameter int NUM_RESOURCES = 16,
    parameter int QUEUE_DEPTH   = 16,
    parameter int TASK_ID_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  frlq_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output frlq_pkg::t_out_item o_out
);
    import frlq_pkg::*;

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(NUM_RESOURCES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_RM_PASS,
        S_RM_LOAD,
        S_RM_OUT
    } t_state;

    t_state                  r_state;
    logic [SW-1:0]           r_step;
    logic [NW-1:0]           r_rep_cnt;
    logic [TASK_ID_BITS-1:0] r_tid;
    t_out_item               r_pend, r_out, w_resp, w_byp;
    logic                    r_out_valid;

    logic                    w_accept, w_bypass, w_out_free, w_load;
    logic [TASK_ID_BITS-1:0] w_tid, w_cmd_tid;
    t_cell_op                w_op    [NUM_RESOURCES];
    t_out_item               w_cresp [NUM_RESOURCES];
    t_out_item               w_chain [NUM_RESOURCES+1];

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = ((r_state == S_SEND) || (r_state == S_RM_OUT)) && w_out_free;
    assign w_tid       = TASK_ID_BITS'(i_in.task_id);
    assign w_cmd_tid   = (r_state == S_IDLE) ? w_tid : r_tid;
    assign w_bypass    = (7'(i_in.resource) >= 7'(NUM_RESOURCES)) || i_in.caller_untracked;

    always_comb begin
        w_byp              = '0;
        w_byp.status       = ST_BYPASS;
        w_byp.resource_out = i_in.resource;
        w_byp.last         = 1'b1;
    end

    always_comb begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            w_op[r] = CELL_NOP;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.req_type)
                            REQ_TAKE: begin
                                if (!w_bypass && (7'(i_in.resource) == 7'(r))) begin
                                    w_op[r] = CELL_TAKE;
                                end
                            end
                            REQ_GIVE: begin
                                if (!w_bypass && (7'(i_in.resource) == 7'(r))) begin
                                    w_op[r] = CELL_GIVE;
                                end
                            end
                            REQ_REMOVE: w_op[r] = CELL_START;
                            default: ;
                        endcase
                    end
                end
                S_RM_PASS: w_op[r] = CELL_STEP;
                S_RM_LOAD: w_op[r] = CELL_REPORT;
                S_RM_OUT: begin
                    if (w_out_free) begin
                        w_op[r] = CELL_SHIFT;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_resp = '0;
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            if (7'(i_in.resource) == 7'(r)) begin
                w_resp = w_cresp[r];
            end
        end
    end

    assign w_chain[NUM_RESOURCES] = '0;

    for (genvar g = 0; g < NUM_RESOURCES; g++) begin : g_cell
        frlq_cell #(
            .QUEUE_DEPTH   (QUEUE_DEPTH),
            .TASK_ID_BITS  (TASK_ID_BITS),
            .NUM_RESOURCES (NUM_RESOURCES),
            .CELL_INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op[g]),
            .i_tid   (w_cmd_tid),
            .i_step  (r_step),
            .i_chain (w_chain[g+1]),
            .o_chain (w_chain[g]),
            .o_resp  (w_cresp[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_rep_cnt   <= '0;
        end else begin
            r_out_valid <= w_load || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.req_type)
                            REQ_TAKE, REQ_GIVE: begin
                                r_pend  <= w_bypass ? w_byp : w_resp;
                                r_state <= S_SEND;
                            end
                            REQ_REMOVE: begin
                                r_tid   <= w_tid;
                                r_step  <= '0;
                                r_state <= S_RM_PASS;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SEND: begin
                    if (w_out_free) begin
                        r_out       <= r_pend;
                        r_state     <= S_IDLE;
                    end
                end
                S_RM_PASS: begin
                    r_step <= r_step + SW'(1);
                    if (r_step == SW'(QUEUE_DEPTH - 1)) begin
                        r_state <= S_RM_LOAD;
                    end
                end
                S_RM_LOAD: begin
                    r_rep_cnt <= '0;
                    r_state   <= S_RM_OUT;
                end
                S_RM_OUT: begin
                    // advance the report chain by one per output transfer
                    if (w_out_free) begin
                        r_out       <= w_chain[0];
                        r_rep_cnt   <= r_rep_cnt + NW'(1);
                        if (r_rep_cnt == NW'(NUM_RESOURCES - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- rtl/frlq_checker.sv -----
// Port-level checker for the resource lock queues, bound to the top level.
`timescale 1ns / 1ps
`include "fifo_resource_lock_queues_top_defines.svh"
module frlq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input frlq_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input frlq_pkg::t_out_item o_out
);
    import frlq_pkg::*;

    `FRLQ_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))
    `FRLQ_AST_IMPL(a_single_last, i_clk, i_rst_n, o_out_valid && (o_out.status != ST_REMOVE), o_out.last)
    `FRLQ_AST_IMPL(a_wake_zero, i_clk, i_rst_n, o_out_valid && !o_out.wake_valid, o_out.wake_task == '0)
    `FRLQ_AST_IMPL(a_removed_kind, i_clk, i_rst_n, o_out_valid && o_out.was_removed, o_out.status == ST_REMOVE)
    `FRLQ_AST_NEXT(a_busy_after, i_clk, i_rst_n, i_in_valid && !o_in_stall && ((i_in.req_type == REQ_TAKE) || (i_in.req_type == REQ_GIVE) || (i_in.req_type == REQ_REMOVE)), o_in_stall)

endmodule

bind fifo_resource_lock_queues_top frlq_checker u_frlq_checker (.*);
